// File: src/tcl_line_completeness_checker_defines.svh
// Assertion macros used by the line completeness checker assertion module.
// No dependencies.
`ifndef TCL_LINE_COMPLETENESS_CHECKER_DEFINES_SVH
`define TCL_LINE_COMPLETENESS_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define TCL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tcl_lcc_pkg.sv
// Package for the line completeness checker: closer codes, status codes,
// character constants and the stack shift control type. No dependencies.
package tcl_lcc_pkg;

    localparam int unsigned MAX_NESTING_DEF = 64;

    typedef logic [1:0] t_closer;
    typedef logic [1:0] t_status;
    typedef logic [7:0] t_char;

    localparam t_closer CL_SQUARE = 2'd0;
    localparam t_closer CL_CURLY  = 2'd1;
    localparam t_closer CL_DQUOTE = 2'd2;
    localparam t_closer CL_SQUOTE = 2'd3;

    localparam t_status ST_COMPLETE   = 2'd0;
    localparam t_status ST_INCOMPLETE = 2'd1;
    localparam t_status ST_OVERFLOW   = 2'd2;

    localparam t_char CH_LSQUARE   = 8'h5B;
    localparam t_char CH_RSQUARE   = 8'h5D;
    localparam t_char CH_LCURLY    = 8'h7B;
    localparam t_char CH_RCURLY    = 8'h7D;
    localparam t_char CH_DQUOTE    = 8'h22;
    localparam t_char CH_SQUOTE    = 8'h27;
    localparam t_char CH_BACKSLASH = 8'h5C;
    localparam t_char CH_NUL       = 8'h00;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

    function automatic t_char closer_char(input t_closer code);
        t_char c;
        unique case (code)
            CL_SQUARE: c = CH_RSQUARE;
            CL_CURLY:  c = CH_RCURLY;
            CL_DQUOTE: c = CH_DQUOTE;
            default:   c = CH_SQUOTE;
        endcase
        return c;
    endfunction

endpackage

// File: src/tcl_lcc_stack_cell.sv
// One entry of the closer stack, built as a bidirectional shift cell.
// Depends on tcl_lcc_pkg.
module tcl_lcc_stack_cell import tcl_lcc_pkg::*; (
    input  logic       i_clk,
    input  t_shift_ctl i_ctl,
    input  t_closer    i_above,
    input  t_closer    i_below,
    output t_closer    o_code
);

    t_closer r_code;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_code <= i_above;
        end else if (i_ctl.pop) begin
            r_code <= i_below;
        end
    end

    assign o_code = r_code;

endmodule

// File: src/tcl_line_completeness_checker.sv
// Line completeness checker: one byte accepted per cycle unless output stalls.
// Result appears in the cycle after the byte marked line_end is accepted.
// The closer stack is a shift chain with its top in cell 0.
// Synchronous active-low reset clears depth, flags and valid, not the status;
// stack cells hold no reset and are only read below the current depth.
module tcl_line_completeness_checker import tcl_lcc_pkg::*; #(
    parameter int unsigned MAX_NESTING = MAX_NESTING_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_line_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_line_status
);

    localparam int unsigned DW = $clog2(MAX_NESTING + 1);

    t_shift_ctl        w_ctl;
    t_closer           w_code [MAX_NESTING];
    t_closer           n_push_code;
    logic [DW-1:0]     r_depth, n_depth;
    logic              r_esc, n_esc;
    logic              r_done, n_done;
    logic              r_ovf, n_ovf;
    logic              r_out_valid, n_out_valid;
    t_status           r_status, n_status;
    logic              w_take;
    logic              w_top_match;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_take     = i_in_valid && o_in_ready;

    assign w_top_match = (r_depth == '0) ? (i_text_byte == CH_NUL)
                                          : (i_text_byte == closer_char(w_code[0]));

    genvar gi;
    generate
        for (gi = 0; gi < MAX_NESTING; gi++) begin : g_cell
            t_closer w_above, w_below;
            if (gi == 0) begin : g_top
                assign w_above = n_push_code;
            end else begin : g_mid
                assign w_above = w_code[gi-1];
            end
            if (gi == MAX_NESTING - 1) begin : g_bot
                assign w_below = CL_SQUARE;
            end else begin : g_inner
                assign w_below = w_code[gi+1];
            end
            tcl_lcc_stack_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_above (w_above),
                .i_below (w_below),
                .o_code  (w_code[gi])
            );
        end
    endgenerate

    always_comb begin
        logic v_want;
        v_want      = 1'b0;
        n_push_code = CL_SQUARE;
        w_ctl       = '0;
        n_depth     = r_depth;
        n_esc       = r_esc;
        n_done      = r_done;
        n_ovf       = r_ovf;
        if (w_take && !r_done && !r_ovf) begin
            if (r_esc) begin
                n_esc = 1'b0;
            end else if (i_text_byte == CH_LSQUARE) begin
                v_want      = 1'b1;
                n_push_code = CL_SQUARE;
            end else if (i_text_byte == CH_LCURLY) begin
                v_want      = 1'b1;
                n_push_code = CL_CURLY;
            end else if (w_top_match) begin
                if (r_depth == '0) begin
                    n_done = 1'b1;
                end else begin
                    w_ctl.pop = 1'b1;
                    n_depth   = r_depth - 1'b1;
                end
            end else if (i_text_byte == CH_DQUOTE) begin
                v_want      = 1'b1;
                n_push_code = CL_DQUOTE;
            end else if (i_text_byte == CH_SQUOTE) begin
                v_want      = 1'b1;
                n_push_code = CL_SQUOTE;
            end else if (i_text_byte == CH_BACKSLASH) begin
                n_esc = 1'b1;
            end
        end
        if (v_want) begin
            if (r_depth == DW'(MAX_NESTING)) begin
                n_ovf = 1'b1;
            end else begin
                w_ctl.push = 1'b1;
                n_depth    = r_depth + 1'b1;
            end
        end

        if (n_ovf) begin
            n_status = ST_OVERFLOW;
        end else if (n_done || n_depth == '0) begin
            n_status = ST_COMPLETE;
        end else begin
            n_status = ST_INCOMPLETE;
        end

        n_out_valid = r_out_valid && !i_out_ready;
        if (w_take && i_line_end) begin
            n_out_valid = 1'b1;
            n_depth     = '0;
            n_esc       = 1'b0;
            n_done      = 1'b0;
            n_ovf       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_esc       <= 1'b0;
            r_done      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_depth     <= n_depth;
            r_esc       <= n_esc;
            r_done      <= n_done;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_line_end) begin
            r_status <= n_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_status = r_status;

endmodule

// File: src/tcl_lcc_checker.sv
// Port-level assertions for the line completeness checker, bound to the top.
// Depends on tcl_line_completeness_checker_defines.svh.
`include "tcl_line_completeness_checker_defines.svh"

module tcl_lcc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_text_byte,
    input logic       i_line_end,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_line_status
);

    logic w_last_acc;
    assign w_last_acc = i_in_valid && o_in_ready && i_line_end;

    `TCL_ASSERT_NXT(a_reset_clears, i_clk, 1'b1, !i_rst_n, !o_out_valid, "valid after reset")
    `TCL_ASSERT_NXT(a_last_gives_item, i_clk, i_rst_n, w_last_acc, o_out_valid, "result missing")
    `TCL_ASSERT_NXT(a_no_invented, i_clk, i_rst_n,
                    (!o_out_valid || i_out_ready) && !w_last_acc, !o_out_valid,
                    "result without line end")
    `TCL_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_out_valid,
                    o_line_status != 2'd3, "status code unused")
    `TCL_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready,
                    o_out_valid && $stable(o_line_status), "stalled result changed")

endmodule

bind tcl_line_completeness_checker tcl_lcc_checker u_tcl_lcc_checker (.*);
